>>> rtl/beam_break_lap_timer_assert.svh
// Assertion macros for the lap timer. Each macro checks a property on the
// rising edge of clk and is switched off while rst_n is low.
`ifndef BEAM_BREAK_LAP_TIMER_ASSERT_SVH
`define BEAM_BREAK_LAP_TIMER_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define BBLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BBLT_ASSERT_NOW(label, ante, cons, msg)
`define BBLT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/bblt_pkg.sv
`default_nettype none

package bblt_pkg;

  // Moving average depth and field widths.
  localparam int AvgDepth = 25;
  localparam int SampleW  = 12;
  localparam int DropW    = 12;
  localparam int TickW    = 16;
  localparam int TimeW    = 24;
  localparam int LapW     = 8;
  localparam int FuncW    = 2;
  localparam int PhaseW   = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Width of the running sum of a full window.
  localparam int SumW = $clog2(AvgDepth * ((1 << SampleW) - 1) + 1);
  // Width of AvgDepth * (sample + drop + 1).
  localparam int ThrW = $clog2(AvgDepth * ((1 << (SampleW + 1)) - 1) + 1);

  // Commands.
  localparam logic [FuncW-1:0] FUNC_TICK = 2'd0;
  localparam logic [FuncW-1:0] FUNC_ARM  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_STOP = 2'd2;

  // Run phases.
  localparam logic [PhaseW-1:0] PH_STOPPED = 2'd0;
  localparam logic [PhaseW-1:0] PH_WAITING = 2'd1;
  localparam logic [PhaseW-1:0] PH_TIMING  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DROP_A  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DROP_B  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LOCKOUT = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_HOLD    = 2'd3;

  // One result item.
  typedef struct packed {
    logic              hit_a;
    logic              hit_b;
    logic              lap_recorded;
    logic [TimeW-1:0]  lap_ticks;
    logic [TimeW-1:0]  pass_interval;
    logic [LapW-1:0]   lap_number;
    logic [PhaseW-1:0] phase;
    logic [TimeW-1:0]  shown_ticks;
    logic [TimeW-1:0]  best_ticks;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/bblt_cell.sv
`default_nettype none

// One entry of a sample window. On a shift it takes the value of the
// neighbour upstream and offers its own to the neighbour downstream.
module bblt_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         shift_en,
  input  wire logic [bblt_pkg::SampleW-1:0] d,
  output logic      [bblt_pkg::SampleW-1:0] q
);

  logic [bblt_pkg::SampleW-1:0] q_r;
  logic [bblt_pkg::SampleW-1:0] q_nxt;

  assign q_nxt = shift_en ? d : q_r;
  assign q     = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bblt_window.sv
`default_nettype none

// Moving-average window for one beam: a chain of cells plus a running sum.
// The break test sample + drop < floor(sum / depth) is evaluated as
// depth * (sample + drop + 1) <= sum, so no divider is needed.
module bblt_window (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         shift_en,
  input  wire logic [bblt_pkg::SampleW-1:0] sample,
  input  wire logic [bblt_pkg::DropW-1:0]   drop,
  output logic                              hit
);

  logic [bblt_pkg::SampleW-1:0] tap [bblt_pkg::AvgDepth+1];
  logic [bblt_pkg::SumW-1:0]    sum_r;
  logic [bblt_pkg::SumW-1:0]    sum_nxt;
  logic [bblt_pkg::ThrW-1:0]    level;
  logic [bblt_pkg::ThrW-1:0]    thr;

  assign tap[0] = sample;

  for (genvar i = 0; i < bblt_pkg::AvgDepth; i++) begin : g_cell
    bblt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (tap[i]),
      .q        (tap[i+1])
    );
  end

  // The oldest sample leaves at the end of the chain as the new one enters.
  assign sum_nxt = sum_r - bblt_pkg::SumW'(tap[bblt_pkg::AvgDepth])
                 + bblt_pkg::SumW'(sample);

  assign level = bblt_pkg::ThrW'(sample) + bblt_pkg::ThrW'(drop) + bblt_pkg::ThrW'(1);
  assign thr   = bblt_pkg::ThrW'(bblt_pkg::AvgDepth) * level;
  assign hit   = bblt_pkg::ThrW'(sum_nxt) >= thr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (shift_en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/beam_break_lap_timer.sv
`default_nettype none
`include "beam_break_lap_timer_assert.svh"

// Beam-break lap timer. Each command transfer on the in_ channel produces
// exactly one result transfer on the out_ channel, in order. A tick pushes
// both ADC samples into 25-entry moving-average windows (unless the timer is
// stopped) and flags a beam as broken when its sample lies below the floor
// of its average minus the drop threshold. Arm clears the run and waits for
// beam A; the next beam-A break starts timing, and later beam-A breaks that
// come at least lockout_ticks after the previous lap record a lap, reported
// with its duration and the time since the last accepted beam-B pass. Stop
// holds the best lap on the display once a lap is on record. One command is
// taken every clock cycle while in_ready is high: the windows keep running
// sums, so the whole update of a command, including both threshold tests and
// the lap bookkeeping, completes in the cycle of its transfer. An output
// register backed by one skid register lets input transfers continue while
// the consumer stalls; in_ready drops only when both are full.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata
// and must only be changed while no command is outstanding.
module beam_break_lap_timer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bblt_pkg::FuncW-1:0]     in_func,
  input  wire logic [bblt_pkg::SampleW-1:0]   in_sample_a,
  input  wire logic [bblt_pkg::SampleW-1:0]   in_sample_b,

  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_hit_a,
  output logic                                out_hit_b,
  output logic                                out_lap_recorded,
  output logic      [bblt_pkg::TimeW-1:0]     out_lap_ticks,
  output logic      [bblt_pkg::TimeW-1:0]     out_pass_interval,
  output logic      [bblt_pkg::LapW-1:0]      out_lap_number,
  output logic      [bblt_pkg::PhaseW-1:0]    out_phase,
  output logic      [bblt_pkg::TimeW-1:0]     out_shown_ticks,
  output logic      [bblt_pkg::TimeW-1:0]     out_best_ticks,

  input  wire logic                           cfg_we,
  input  wire logic [bblt_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [bblt_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int TW = bblt_pkg::TimeW;

  // Configuration registers.
  logic [bblt_pkg::DropW-1:0] drop_a_r;
  logic [bblt_pkg::DropW-1:0] drop_b_r;
  logic [bblt_pkg::TickW-1:0] lockout_r;
  logic [bblt_pkg::TickW-1:0] hold_r;

  // Run state.
  logic [bblt_pkg::PhaseW-1:0] phase_r,     phase_nxt;
  logic [TW-1:0]               elapsed_r,   elapsed_nxt;
  logic [TW-1:0]               last_lap_r,  last_lap_nxt;
  logic [TW-1:0]               last_pass_r, last_pass_nxt;
  logic                        hold_vld_r,  hold_vld_nxt;
  logic [TW-1:0]               hold_base_r, hold_base_nxt;
  logic [bblt_pkg::LapW-1:0]   lap_cnt_r,   lap_cnt_nxt;
  logic [TW-1:0]               best_r,      best_nxt;

  // Output register and skid register.
  logic                 out_vld_r, out_vld_nxt;
  bblt_pkg::res_t       out_res_r, out_res_nxt;
  logic                 skid_vld_r, skid_vld_nxt;
  bblt_pkg::res_t       skid_res_r, skid_res_nxt;

  logic                 accept;
  logic                 tick_en;
  logic                 win_hit_a;
  logic                 win_hit_b;
  logic                 hit_a;
  logic                 hit_b;
  logic                 lap_ok;
  logic                 lap;
  logic [TW-1:0]        lap_len;
  logic [TW-1:0]        pass_gap;
  logic [TW-1:0]        best_sel;
  bblt_pkg::res_t       res;

  assign in_ready = !skid_vld_r;
  assign accept   = in_valid && in_ready;
  // Samples are only taken while the timer is armed or timing.
  assign tick_en  = accept && (in_func == bblt_pkg::FUNC_TICK)
                  && (phase_r != bblt_pkg::PH_STOPPED);

  bblt_window u_win_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (tick_en),
    .sample   (in_sample_a),
    .drop     (drop_a_r),
    .hit      (win_hit_a)
  );

  bblt_window u_win_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (tick_en),
    .sample   (in_sample_b),
    .drop     (drop_b_r),
    .hit      (win_hit_b)
  );

  assign hit_a = tick_en && win_hit_a;
  assign hit_b = tick_en && win_hit_b;

  // A lap counts only once the lockout since the previous lap mark is over.
  // The sum is one bit wider so that it cannot wrap.
  assign lap_ok   = {1'b0, elapsed_r} >= ({1'b0, last_lap_r} + (TW+1)'(lockout_r));
  assign lap_len  = elapsed_r - last_lap_r;
  assign pass_gap = (elapsed_r >= last_pass_r) ? (elapsed_r - last_pass_r) : '0;
  assign best_sel = (elapsed_r < best_r) ? elapsed_r : best_r;

  // Next-state logic for one command.
  always_comb begin
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    last_lap_nxt  = last_lap_r;
    last_pass_nxt = last_pass_r;
    hold_vld_nxt  = hold_vld_r;
    hold_base_nxt = hold_base_r;
    lap_cnt_nxt   = lap_cnt_r;
    best_nxt      = best_r;
    lap           = 1'b0;

    case (in_func)
      bblt_pkg::FUNC_ARM: begin
        phase_nxt     = bblt_pkg::PH_WAITING;
        elapsed_nxt   = '0;
        last_lap_nxt  = '0;
        last_pass_nxt = '0;
        hold_vld_nxt  = 1'b0;
        hold_base_nxt = '0;
        lap_cnt_nxt   = '0;
        best_nxt      = '1;
      end
      bblt_pkg::FUNC_STOP: begin
        phase_nxt = bblt_pkg::PH_STOPPED;
        // With at least one lap on record the best lap is put on display.
        if (lap_cnt_r != '0) begin
          hold_vld_nxt  = 1'b1;
          hold_base_nxt = last_lap_r - best_sel;
        end
      end
      bblt_pkg::FUNC_TICK: begin
        if (phase_r != bblt_pkg::PH_STOPPED) begin
          if (hit_a) begin
            if ((phase_r == bblt_pkg::PH_TIMING) && lap_ok) begin
              lap          = 1'b1;
              lap_cnt_nxt  = lap_cnt_r + bblt_pkg::LapW'(1);
              if (lap_len < best_r) begin
                best_nxt = lap_len;
              end
              hold_vld_nxt  = 1'b1;
              hold_base_nxt = last_lap_r;
              last_lap_nxt  = elapsed_r;
            end else if (phase_r == bblt_pkg::PH_WAITING) begin
              // The first beam-A break starts a fresh run.
              phase_nxt     = bblt_pkg::PH_TIMING;
              elapsed_nxt   = '0;
              last_lap_nxt  = '0;
              last_pass_nxt = '0;
              hold_vld_nxt  = 1'b0;
              hold_base_nxt = '0;
              lap_cnt_nxt   = '0;
              best_nxt      = '1;
            end
          end
          // Beam-B passes are checked against the marks as updated above.
          if (hit_b && ({1'b0, elapsed_nxt} >=
                        ({1'b0, last_pass_nxt} + (TW+1)'(lockout_r)))) begin
            last_pass_nxt = elapsed_nxt;
          end
          // The lap display expires once the hold time has run out.
          if (({1'b0, last_lap_nxt} + (TW+1)'(hold_r)) < {1'b0, elapsed_nxt}) begin
            hold_vld_nxt = 1'b0;
          end
          // The running clock saturates rather than wrapping.
          if ((phase_nxt == bblt_pkg::PH_TIMING) && (elapsed_nxt != '1)) begin
            elapsed_nxt = elapsed_nxt + TW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result of the command being transferred in this cycle.
  always_comb begin
    res.hit_a         = hit_a;
    res.hit_b         = hit_b;
    res.lap_recorded  = lap;
    res.lap_ticks     = lap ? lap_len : '0;
    res.pass_interval = lap ? pass_gap : '0;
    res.lap_number    = lap_cnt_nxt;
    res.phase         = phase_nxt;
    res.shown_ticks   = hold_vld_nxt ? (last_lap_nxt - hold_base_nxt) : elapsed_nxt;
    res.best_ticks    = best_nxt;
  end

  // Output register with one skid entry behind it.
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = accept;
        out_res_nxt = res;
      end
    end else if (accept) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_a_r    <= bblt_pkg::DropW'(300);
      drop_b_r    <= bblt_pkg::DropW'(150);
      lockout_r   <= bblt_pkg::TickW'(1000);
      hold_r      <= bblt_pkg::TickW'(2000);
    end else if (cfg_we) begin
      case (cfg_index)
        bblt_pkg::REG_DROP_A:  drop_a_r  <= cfg_wdata[bblt_pkg::DropW-1:0];
        bblt_pkg::REG_DROP_B:  drop_b_r  <= cfg_wdata[bblt_pkg::DropW-1:0];
        bblt_pkg::REG_LOCKOUT: lockout_r <= cfg_wdata[bblt_pkg::TickW-1:0];
        bblt_pkg::REG_HOLD:    hold_r    <= cfg_wdata[bblt_pkg::TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= bblt_pkg::PH_STOPPED;
      elapsed_r   <= '0;
      last_lap_r  <= '0;
      last_pass_r <= '0;
      hold_vld_r  <= 1'b0;
      hold_base_r <= '0;
      lap_cnt_r   <= '0;
      best_r      <= '1;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      last_lap_r  <= last_lap_nxt;
      last_pass_r <= last_pass_nxt;
      hold_vld_r  <= hold_vld_nxt;
      hold_base_r <= hold_base_nxt;
      lap_cnt_r   <= lap_cnt_nxt;
      best_r      <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_hit_a         = out_res_r.hit_a;
  assign out_hit_b         = out_res_r.hit_b;
  assign out_lap_recorded  = out_res_r.lap_recorded;
  assign out_lap_ticks     = out_res_r.lap_ticks;
  assign out_pass_interval = out_res_r.pass_interval;
  assign out_lap_number    = out_res_r.lap_number;
  assign out_phase         = out_res_r.phase;
  assign out_shown_ticks   = out_res_r.shown_ticks;
  assign out_best_ticks    = out_res_r.best_ticks;

  // The skid entry is only ever filled behind a waiting output register.
  `BBLT_ASSERT_NOW(a_skid_behind_out, skid_vld_r, out_vld_r, "skid full with output empty")
  // A transfer in while the output stalls must land in the skid entry.
  `BBLT_ASSERT_NEXT(a_stall_to_skid, accept && out_vld_r && !out_ready, skid_vld_r,
                    "stalled result not kept")
  // A recorded lap only happens while timing, and the best lap covers it.
  `BBLT_ASSERT_NOW(a_lap_timing, out_vld_r && out_lap_recorded,
                   (out_phase == bblt_pkg::PH_TIMING) && (out_best_ticks <= out_lap_ticks),
                   "lap result inconsistent")
  // A stopped timer reports no beam breaks.
  `BBLT_ASSERT_NOW(a_stopped_no_hit, accept && (phase_r == bblt_pkg::PH_STOPPED),
                   !hit_a && !hit_b, "hit while stopped")

endmodule

`default_nettype wire

>>> test/beam_break_lap_timer_tb.sv
// Self-checking bench for the beam-break lap timer.
//
// Every command transfer into the block is mirrored by a cycle-free behavioural
// model kept in this module. The model produces the result the block should
// return for that command. Results are queued in order and each result
// transfer on the out_ channel is compared field by field against the oldest
// entry. The stimulus has three parts. A short directed run covers the corner
// cases. A long timing session drives the lap counter past its wrap. Random
// sessions follow, run under several idling patterns and register settings.
module beam_break_lap_timer_tb;

  // The command code that the block must ignore.
  localparam logic [bblt_pkg::FuncW-1:0] FUNC_SPARE = 2'd3;

  // Register values after reset.
  localparam logic [bblt_pkg::DropW-1:0] DROP_A_RESET  = 12'd300;
  localparam logic [bblt_pkg::DropW-1:0] DROP_B_RESET  = 12'd150;
  localparam logic [bblt_pkg::TickW-1:0] LOCKOUT_RESET = 16'd1000;
  localparam logic [bblt_pkg::TickW-1:0] HOLD_RESET    = 16'd2000;

  localparam int LONG_STALL  = 300;     // cycles of the long consumer hold-off
  localparam int DRAIN_TAIL  = 4;       // settling margin after the last result
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [bblt_pkg::FuncW-1:0]    in_func = bblt_pkg::FUNC_TICK;
  logic [bblt_pkg::SampleW-1:0]  in_sample_a = '0;
  logic [bblt_pkg::SampleW-1:0]  in_sample_b = '0;

  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_hit_a;
  logic                          out_hit_b;
  logic                          out_lap_recorded;
  logic [bblt_pkg::TimeW-1:0]    out_lap_ticks;
  logic [bblt_pkg::TimeW-1:0]    out_pass_interval;
  logic [bblt_pkg::LapW-1:0]     out_lap_number;
  logic [bblt_pkg::PhaseW-1:0]   out_phase;
  logic [bblt_pkg::TimeW-1:0]    out_shown_ticks;
  logic [bblt_pkg::TimeW-1:0]    out_best_ticks;

  logic                          cfg_we = 1'b0;
  logic [bblt_pkg::CfgIdxW-1:0]  cfg_index = bblt_pkg::REG_DROP_A;
  logic [bblt_pkg::CfgDataW-1:0] cfg_wdata = '0;

  beam_break_lap_timer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_sample_a       (in_sample_a),
    .in_sample_b       (in_sample_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit_a         (out_hit_a),
    .out_hit_b         (out_hit_b),
    .out_lap_recorded  (out_lap_recorded),
    .out_lap_ticks     (out_lap_ticks),
    .out_pass_interval (out_pass_interval),
    .out_lap_number    (out_lap_number),
    .out_phase         (out_phase),
    .out_shown_ticks   (out_shown_ticks),
    .out_best_ticks    (out_best_ticks),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Bookkeeping shared by the stimulus, the consumer and the result checker.
  bblt_pkg::res_t pending_results[$];
  int unsigned send_gap_pct = 0;      // chance in a hundred that the sender idles a cycle
  int unsigned stall_pct = 0;         // chance in a hundred that the consumer stalls
  int          long_stalls_asked = 0;
  int          long_stalls_done = 0;
  int          long_stall_left = 0;
  int          mismatches = 0;
  int          commands_sent = 0;
  int          results_checked = 0;
  int          laps_checked = 0;
  int          reg_writes = 0;
  int          cycles = 0;

  // ---------------------------------------------------------------------------
  // Behavioural model of the timer: configuration, windows and run state.
  // ---------------------------------------------------------------------------
  logic [bblt_pkg::DropW-1:0]   thr_a, thr_b;
  logic [bblt_pkg::TickW-1:0]   lockout_len, hold_len;
  logic [bblt_pkg::SampleW-1:0] window [2][bblt_pkg::AvgDepth];
  int                           slot [2];
  logic [bblt_pkg::PhaseW-1:0]  mode;
  logic [bblt_pkg::TimeW-1:0]   t_elapsed, lap_mark, pass_mark, hold_ref, fastest;
  logic                         hold_on;
  logic [bblt_pkg::LapW-1:0]    laps;

  function automatic void clear_run();
    t_elapsed = '0;
    lap_mark  = '0;
    pass_mark = '0;
    hold_on   = 1'b0;
    hold_ref  = '0;
    laps      = '0;
    fastest   = '1;
  endfunction

  function automatic void reset_prediction();
    thr_a       = DROP_A_RESET;
    thr_b       = DROP_B_RESET;
    lockout_len = LOCKOUT_RESET;
    hold_len    = HOLD_RESET;
    for (int b = 0; b < 2; b++) begin
      slot[b] = 0;
      for (int i = 0; i < bblt_pkg::AvgDepth; i++) window[b][i] = '0;
    end
    mode = bblt_pkg::PH_STOPPED;
    clear_run();
  endfunction

  // Pushes a sample into its beam's window and tests it against the floor of
  // the window average, which already includes the new sample. Sums are wide
  // enough that a drop larger than the average can never produce a break.
  function automatic logic push_sample(int beam, logic [bblt_pkg::SampleW-1:0] s,
                                       logic [bblt_pkg::DropW-1:0] drop);
    int unsigned total;
    total = 0;
    window[beam][slot[beam]] = s;
    slot[beam] = (slot[beam] + 1) % bblt_pkg::AvgDepth;
    for (int i = 0; i < bblt_pkg::AvgDepth; i++) total += window[beam][i];
    return (32'(s) + 32'(drop)) < (total / bblt_pkg::AvgDepth);
  endfunction

  // Advances the model by one command and returns the result it should cause.
  function automatic bblt_pkg::res_t predict_timer_result(
      logic [bblt_pkg::FuncW-1:0] cmd, logic [bblt_pkg::SampleW-1:0] sa,
      logic [bblt_pkg::SampleW-1:0] sb);
    bblt_pkg::res_t             r;
    logic [bblt_pkg::TimeW-1:0] best;
    r = '0;
    if (cmd == bblt_pkg::FUNC_ARM) begin
      mode = bblt_pkg::PH_WAITING;
      clear_run();
    end else if (cmd == bblt_pkg::FUNC_STOP) begin
      mode = bblt_pkg::PH_STOPPED;
      // With laps on record the best lap is put on display; the held value
      // is lap_mark - hold_ref, so the base is chosen to give the best time.
      if (laps != '0) begin
        best     = (t_elapsed < fastest) ? t_elapsed : fastest;
        hold_on  = 1'b1;
        hold_ref = lap_mark - best;
      end
    end else if (cmd == bblt_pkg::FUNC_TICK && mode != bblt_pkg::PH_STOPPED) begin
      r.hit_a = push_sample(0, sa, thr_a);
      r.hit_b = push_sample(1, sb, thr_b);
      if (r.hit_a) begin
        if (mode == bblt_pkg::PH_TIMING &&
            32'(t_elapsed) >= 32'(lap_mark) + 32'(lockout_len)) begin
          r.lap_recorded  = 1'b1;
          r.lap_ticks     = t_elapsed - lap_mark;
          r.pass_interval = (t_elapsed >= pass_mark) ? t_elapsed - pass_mark : '0;
          laps++;
          if (r.lap_ticks < fastest) fastest = r.lap_ticks;
          hold_on  = 1'b1;
          hold_ref = lap_mark;
          lap_mark = t_elapsed;
        end else if (mode == bblt_pkg::PH_WAITING) begin
          mode = bblt_pkg::PH_TIMING;
          clear_run();
        end
      end
      // The beam-B check sees the marks as updated above.
      if (r.hit_b && 32'(t_elapsed) >= 32'(pass_mark) + 32'(lockout_len))
        pass_mark = t_elapsed;
      if (32'(lap_mark) + 32'(hold_len) < 32'(t_elapsed)) hold_on = 1'b0;
      if (mode == bblt_pkg::PH_TIMING && t_elapsed != '1) t_elapsed++;
    end
    r.lap_number  = laps;
    r.phase       = mode;
    r.shown_ticks = hold_on ? lap_mark - hold_ref : t_elapsed;
    r.best_ticks  = fastest;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus primitives.
  // ---------------------------------------------------------------------------

  // Offers one command and waits for its transfer. Valid is lowered only when
  // the sender decides to idle, so back-to-back commands keep it high.
  task automatic send_item(logic [bblt_pkg::FuncW-1:0] cmd,
                           logic [bblt_pkg::SampleW-1:0] sa,
                           logic [bblt_pkg::SampleW-1:0] sb);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid    <= 1'b1;
    in_func     <= cmd;
    in_sample_a <= sa;
    in_sample_b <= sb;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_timer_result(cmd, sa, sb));
    commands_sent++;
  endtask

  // Stops offering commands and waits until every expected result has come,
  // then lets the pipeline settle.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(logic [bblt_pkg::CfgIdxW-1:0] idx,
                           logic [bblt_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      bblt_pkg::REG_DROP_A:  thr_a       = data[bblt_pkg::DropW-1:0];
      bblt_pkg::REG_DROP_B:  thr_b       = data[bblt_pkg::DropW-1:0];
      bblt_pkg::REG_LOCKOUT: lockout_len = data[bblt_pkg::TickW-1:0];
      bblt_pkg::REG_HOLD:    hold_len    = data[bblt_pkg::TickW-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Only ever called with the block drained.
  task automatic configure(logic [bblt_pkg::CfgDataW-1:0] da,
                           logic [bblt_pkg::CfgDataW-1:0] db,
                           logic [bblt_pkg::CfgDataW-1:0] lock,
                           logic [bblt_pkg::CfgDataW-1:0] hold);
    write_reg(bblt_pkg::REG_DROP_A, da);
    write_reg(bblt_pkg::REG_DROP_B, db);
    write_reg(bblt_pkg::REG_LOCKOUT, lock);
    write_reg(bblt_pkg::REG_HOLD, hold);
  endtask

  task automatic set_idling(int unsigned gap, int unsigned stall);
    send_gap_pct = gap;
    stall_pct    = stall;
  endtask

  // A clear beam reads high; a broken beam reads low. pct is the chance in a
  // hundred that the beam is broken on a given tick.
  function automatic logic [bblt_pkg::SampleW-1:0] beam_sample(int unsigned pct);
    if ($urandom_range(99) < pct) return bblt_pkg::SampleW'($urandom_range(900));
    return bblt_pkg::SampleW'($urandom_range(4095, 3000));
  endfunction

  function automatic logic [bblt_pkg::SampleW-1:0] any_sample();
    return bblt_pkg::SampleW'($urandom_range(4095));
  endfunction

  // One armed session: arm, a run of ticks with plausible beam readings, then
  // a stop. With noise enabled a few stray stops, re-arms, ignored codes and
  // full-range readings are mixed in.
  task automatic lap_session(int n, int unsigned pct_a, int unsigned pct_b,
                             bit noisy);
    int unsigned roll;
    send_item(bblt_pkg::FUNC_ARM, any_sample(), any_sample());
    for (int k = 0; k < n; k++) begin
      roll = noisy ? $urandom_range(99) : 99;
      if (roll < 2) begin
        // A stray stop, a few ticks while stopped, and the timer is re-armed.
        send_item(bblt_pkg::FUNC_STOP, any_sample(), any_sample());
        repeat ($urandom_range(3))
          send_item(bblt_pkg::FUNC_TICK, any_sample(), any_sample());
        send_item(bblt_pkg::FUNC_ARM, any_sample(), any_sample());
      end else if (roll < 3) begin
        send_item(FUNC_SPARE, any_sample(), any_sample());
      end else if (roll < 4) begin
        send_item(bblt_pkg::FUNC_ARM, any_sample(), any_sample());
      end else if (roll < 9) begin
        send_item(bblt_pkg::FUNC_TICK, any_sample(), any_sample());
      end else begin
        send_item(bblt_pkg::FUNC_TICK, beam_sample(pct_a), beam_sample(pct_b));
      end
    end
    send_item(bblt_pkg::FUNC_STOP, any_sample(), any_sample());
    if ($urandom_range(1) == 1)
      send_item(bblt_pkg::FUNC_STOP, any_sample(), any_sample());
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Corner cases, first with the register values left by reset.
  task automatic test_directed_cases();
    set_idling(0, 0);
    // Ticks while stopped take no samples and change nothing.
    send_item(bblt_pkg::FUNC_TICK, 12'd0, 12'd0);
    send_item(bblt_pkg::FUNC_TICK, 12'hFFF, 12'hFFF);
    send_item(FUNC_SPARE, 12'hFFF, 12'hFFF);
    // Stop with no laps on record must not put anything on hold.
    send_item(bblt_pkg::FUNC_STOP, 12'd0, 12'd0);
    send_item(bblt_pkg::FUNC_ARM, 12'hFFF, 12'd0);
    // The windows are still empty, so the threshold lies below zero.
    send_item(bblt_pkg::FUNC_TICK, 12'd0, 12'd0);
    repeat (3) send_item(bblt_pkg::FUNC_TICK, 12'hFFF, 12'hFFF);
    // A dark beam A now starts timing; beam B breaks on the same tick.
    send_item(bblt_pkg::FUNC_TICK, 12'd0, 12'd0);
    wait_until_drained();

    // Short lockout and hold so that laps and hold expiry come quickly.
    write_reg(bblt_pkg::REG_LOCKOUT, 16'd3);
    write_reg(bblt_pkg::REG_HOLD, 16'd4);
    send_item(bblt_pkg::FUNC_TICK, 12'hFFF, 12'hFFF);
    send_item(bblt_pkg::FUNC_TICK, 12'd0, 12'hFFF);      // beam A inside the lockout
    send_item(bblt_pkg::FUNC_TICK, 12'hFFF, 12'd0);      // a beam B pass
    send_item(bblt_pkg::FUNC_TICK, 12'hFFF, 12'hFFF);
    send_item(bblt_pkg::FUNC_TICK, 12'd0, 12'hFFF);      // first lap
    repeat (6) send_item(bblt_pkg::FUNC_TICK, 12'hFFF, 12'h800);  // hold runs out
    send_item(bblt_pkg::FUNC_TICK, 12'd0, 12'h555);      // second lap
    send_item(bblt_pkg::FUNC_STOP, 12'd0, 12'd0);        // best lap on display
    send_item(bblt_pkg::FUNC_STOP, 12'hFFF, 12'hFFF);    // stopping again changes nothing
    send_item(bblt_pkg::FUNC_TICK, 12'hAAA, 12'd0);
    send_item(bblt_pkg::FUNC_ARM, 12'h555, 12'hAAA);
    send_item(FUNC_SPARE, 12'd0, 12'hFFF);
    wait_until_drained();
  endtask

  // Zero thresholds and no lockout: nearly every dark beam A records a lap,
  // so one long session takes the lap counter through its wrap.
  task automatic test_lap_count_wrap();
    set_idling(0, 0);
    configure(16'd0, 16'd0, 16'd0, 16'd0);
    lap_session(360, 85, 30, 1'b0);
    wait_until_drained();
  endtask

  // The consumer holds off for a long stretch while commands keep coming, so
  // the output stage fills and in_ready must fall. Afterwards the sender
  // pauses until every result is back before carrying on.
  task automatic test_backpressure();
    set_idling(0, 0);
    configure(16'd400, 16'd300, 16'd5, 16'd8);
    long_stalls_asked++;
    lap_session(40, 15, 15, 1'b1);
    wait_until_drained();
    lap_session(40, 15, 15, 1'b1);
    wait_until_drained();
  endtask

  task automatic test_sender_gaps();
    set_idling(85, 0);
    configure(16'($urandom_range(1500)), 16'($urandom_range(1500)),
              16'($urandom_range(12)), 16'($urandom_range(25)));
    repeat (2) lap_session(40, 15, 15, 1'b1);
    wait_until_drained();
  endtask

  // Upper extremes: an endless hold, then an endless lockout with beam B
  // made unbreakable by the largest drop.
  task automatic test_receiver_stalls();
    set_idling(0, 85);
    configure(16'd400, 16'd400, 16'd2, 16'hFFFF);
    lap_session(50, 20, 20, 1'b1);
    wait_until_drained();
    configure(16'd500, 16'hFFF, 16'hFFFF, 16'd0);
    lap_session(40, 20, 20, 1'b1);
    wait_until_drained();
  endtask

  // Full 16-bit write data first, so the drop registers must keep only their
  // low twelve bits; then a workable setting for the bulk of the traffic.
  task automatic test_mixed_idling();
    set_idling(13, 13);
    configure(16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(40)), 16'($urandom_range(60)));
    lap_session(30, 20, 20, 1'b1);
    wait_until_drained();
    configure(16'($urandom_range(1200)), 16'($urandom_range(1200)),
              16'($urandom_range(10)), 16'($urandom_range(30)));
    repeat (2) lap_session(40, 15, 15, 1'b1);
    wait_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Consumer: random stalls, plus a long hold-off whenever one is asked for.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (long_stall_left > 0) begin
      long_stall_left--;
      out_ready <= 1'b0;
    end else if (long_stalls_done != long_stalls_asked) begin
      long_stalls_done = long_stalls_asked;
      long_stall_left  = LONG_STALL;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker. Reports are capped so that a badly broken build cannot
  // flood the log; every mismatch is still counted.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want,
                                      logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t  %s: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    bblt_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t  result transfer: expected none, got lap_number %0d phase %0d",
                 $time, out_lap_number, out_phase);
      end else begin
        want = pending_results.pop_front();
        check_field("hit_a", 32'(want.hit_a), 32'(out_hit_a));
        check_field("hit_b", 32'(want.hit_b), 32'(out_hit_b));
        check_field("lap_recorded", 32'(want.lap_recorded), 32'(out_lap_recorded));
        check_field("lap_ticks", 32'(want.lap_ticks), 32'(out_lap_ticks));
        check_field("pass_interval", 32'(want.pass_interval), 32'(out_pass_interval));
        check_field("lap_number", 32'(want.lap_number), 32'(out_lap_number));
        check_field("phase", 32'(want.phase), 32'(out_phase));
        check_field("shown_ticks", 32'(want.shown_ticks), 32'(out_shown_ticks));
        check_field("best_ticks", 32'(want.best_ticks), 32'(out_best_ticks));
        results_checked++;
        if (want.lap_recorded) laps_checked++;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t  timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_prediction();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_lap_count_wrap();
    test_backpressure();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();

    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0t  %0d expected results never arrived", $time,
               pending_results.size());
    end
    $display("Sent %0d commands and checked %0d results, %0d of them completed laps,",
             commands_sent, results_checked, laps_checked);
    $display("across %0d register writes, four idling patterns and one long stall.",
             reg_writes);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
